// ===== hw/rtl/fblo_pkg.sv =====
// ----------------------------------------------------------------------------
// fblo_pkg
// Shared widths, codes, CORDIC arctangent table and stage structs for the
// four-bar linkage output angle pipeline.
// ----------------------------------------------------------------------------
package fblo_pkg;

   // field formats
   localparam int ANGLE_BITS       = 16;
   localparam int LEN_W            = 16;
   localparam int LENGTH_FRAC_BITS = 12;
   localparam int STATUS_W         = 2;
   localparam int CSR_INDEX_W      = 3;

   // CORDIC
   localparam int CORDIC_STAGES = 16;
   localparam int TURN_W        = 32;   // accumulator: 2^32 per turn
   localparam int TRIG_FRAC     = 30;
   localparam int CORDIC_XINIT  = 652032875;
   localparam int XY_W          = 34;
   localparam int Z_W           = 34;
   localparam int COS_W         = 32;

   // J, K, L and discriminant
   localparam int B_W    = 19;
   localparam int JKL_W  = 24;
   localparam int DEN_W  = JKL_W + 1;
   localparam int D_W    = 48;
   localparam int RAD_W  = 46;
   localparam int ROOT_W = RAD_W / 2;

   // arctangent
   localparam int NUM_W          = 26;
   localparam int NORM_LIMIT_BIT = 40;
   localparam int NORM_W         = NORM_LIMIT_BIT + 2;
   localparam int MAG_W          = NORM_LIMIT_BIT + 1;
   localparam int VEC_W          = 45;

   // reset values of the registers
   localparam logic [LEN_W-1:0] GROUND_LEN_RST  = 16'd3686;
   localparam logic [LEN_W-1:0] CRANK_LEN_RST   = 16'd1229;
   localparam logic [LEN_W-1:0] COUPLER_LEN_RST = 16'd6144;
   localparam logic [LEN_W-1:0] ROCKER_LEN_RST  = 16'd3277;
   localparam logic [ANGLE_BITS-1:0] GROUND_ANG_RST = 16'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GROUND_LENGTH  = 3'd0,
      REG_CRANK_LENGTH   = 3'd1,
      REG_COUPLER_LENGTH = 3'd2,
      REG_ROCKER_LENGTH  = 3'd3,
      REG_GROUND_ANGLE   = 3'd4
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_ASSEMBLY = 2'd1,
      STATUS_ZERO_DEN    = 2'd2
   } status_type;

   // atan(2^-i) in 2^32-per-turn units
   localparam logic [TURN_W-1:0] ATAN_TABLE [0:23] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic [LEN_W-1:0] ground_len;
      logic [LEN_W-1:0] crank_len;
      logic [LEN_W-1:0] coupler_len;
      logic [LEN_W-1:0] rocker_len;
   } cfg_type;

   typedef struct packed {
      logic                    valid;
      logic signed [COS_W-1:0] cos1;
      logic signed [COS_W-1:0] sin1;
      logic signed [COS_W-1:0] cos2;
      logic signed [COS_W-1:0] sin2;
      logic signed [COS_W-1:0] cosd;
   } trig_type;

   typedef struct packed {
      logic                    valid;
      logic signed [D_W-1:0]   disc;
      logic signed [JKL_W-1:0] k;
      logic signed [DEN_W-1:0] den;
   } jkl_type;

   typedef struct packed {
      logic                    valid;
      logic                    no_asm;
      logic signed [JKL_W-1:0] k;
      logic signed [DEN_W-1:0] den;
      logic [ROOT_W-1:0]       root;
   } root_type;

   typedef struct packed {
      logic                  valid;
      logic [ANGLE_BITS-1:0] angle;
      status_type            status;
   } res_type;

endpackage

// ===== hw/rtl/fblo_trig.sv =====
// ----------------------------------------------------------------------------
// fblo_trig
// Three pipelined CORDIC rotation lanes: cos/sin of the ground angle, the
// crank angle and their difference, one iteration per stage.
// ----------------------------------------------------------------------------
module fblo_trig (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [fblo_pkg::TURN_W-1:0]   t1,
   input  logic [fblo_pkg::TURN_W-1:0]   t2,
   input  logic [fblo_pkg::TURN_W-1:0]   td,
   output fblo_pkg::trig_type            trig_out
);

   localparam int N = fblo_pkg::CORDIC_STAGES;

   logic [fblo_pkg::TURN_W-1:0]           ang [3];
   logic signed [fblo_pkg::COS_W-1:0]     cos_q [3];
   logic signed [fblo_pkg::COS_W-1:0]     sin_q [3];
   logic                                  vld_ff [N+2];

   assign ang[0] = t1;
   assign ang[1] = t2;
   assign ang[2] = td;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic                              flip_in;
      logic [fblo_pkg::TURN_W-1:0]       a_adj;
      logic signed [fblo_pkg::XY_W-1:0]  x_ff [N+1];
      logic signed [fblo_pkg::XY_W-1:0]  y_ff [N+1];
      logic signed [fblo_pkg::Z_W-1:0]   z_ff [N+1];
      logic                              flip_ff [N+1];
      logic signed [fblo_pkg::COS_W-1:0] c_ff;
      logic signed [fblo_pkg::COS_W-1:0] s_ff;

      // fold the left half plane onto the right one
      always_comb begin
         flip_in = (ang[l] > 32'h4000_0000) && (ang[l] < 32'hC000_0000);
         a_adj   = flip_in ? ang[l] + 32'h8000_0000 : ang[l];
      end

      // rotation iterations
      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[0]    <= fblo_pkg::XY_W'(fblo_pkg::CORDIC_XINIT);
            y_ff[0]    <= '0;
            z_ff[0]    <= fblo_pkg::Z_W'($signed(a_adj));
            flip_ff[0] <= flip_in;
            for (int i = 0; i < N; i++) begin
               if (!z_ff[i][fblo_pkg::Z_W-1]) begin
                  x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
                  y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
                  z_ff[i+1] <= z_ff[i] - fblo_pkg::Z_W'(fblo_pkg::ATAN_TABLE[i]);
               end else begin
                  x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
                  y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
                  z_ff[i+1] <= z_ff[i] + fblo_pkg::Z_W'(fblo_pkg::ATAN_TABLE[i]);
               end
               flip_ff[i+1] <= flip_ff[i];
            end
            c_ff <= fblo_pkg::COS_W'(flip_ff[N] ? -x_ff[N] : x_ff[N]);
            s_ff <= fblo_pkg::COS_W'(flip_ff[N] ? -y_ff[N] : y_ff[N]);
         end
      end

      assign cos_q[l] = c_ff;
      assign sin_q[l] = s_ff;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N + 2; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 0; i < N + 1; i++) vld_ff[i+1] <= vld_ff[i];
      end
   end

   assign trig_out.valid = vld_ff[N+1];
   assign trig_out.cos1  = cos_q[0];
   assign trig_out.sin1  = sin_q[0];
   assign trig_out.cos2  = cos_q[1];
   assign trig_out.sin2  = sin_q[1];
   assign trig_out.cosd  = cos_q[2];

endmodule

// ===== hw/rtl/fblo_jkl.sv =====
// ----------------------------------------------------------------------------
// fblo_jkl
// Forms J, K, L from the link lengths and the CORDIC outputs, then the
// discriminant K^2 - L^2 + J^2 and the denominator L - J. Six stages.
// ----------------------------------------------------------------------------
module fblo_jkl (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  fblo_pkg::cfg_type  cfg,
   input  fblo_pkg::trig_type trig_in,
   output fblo_pkg::jkl_type  jkl_out
);

   localparam int F    = fblo_pkg::LENGTH_FRAC_BITS;
   localparam int P_W  = fblo_pkg::LEN_W + 1 + fblo_pkg::COS_W;
   localparam int DC_W = P_W + 1;
   localparam int RS_W = 2 * fblo_pkg::LEN_W + 3;
   localparam int JM_W = fblo_pkg::LEN_W + 2 + fblo_pkg::B_W;
   localparam int LP_W = fblo_pkg::LEN_W + 1 + fblo_pkg::B_W;
   localparam int L2_W = LP_W + 2;
   localparam int SQ_W = 2 * fblo_pkg::JKL_W;
   localparam logic signed [DC_W-1:0] TRIG_HALF = DC_W'(1) <<< (fblo_pkg::TRIG_FRAC - 1);
   localparam logic signed [L2_W-1:0] LEN_HALF  = L2_W'(1) <<< (F - 1);

   logic signed [fblo_pkg::LEN_W:0] r1, r2, r3, r4;

   logic                  vld_ff [6];
   // stage 1
   logic signed [P_W-1:0]  p1c_ff, p2c_ff, p1s_ff, p2s_ff, pu_ff;
   logic signed [RS_W-1:0] rsum1_ff;
   // stage 2
   logic signed [fblo_pkg::B_W-1:0] bc_ff, bs_ff, u_ff;
   logic signed [RS_W-1:0] rsum2_ff;
   // stage 3
   logic signed [JM_W-1:0] jm_ff, km_ff;
   logic signed [LP_W-1:0] lp_ff;
   logic signed [RS_W-1:0] rsum3_ff;
   // stage 4
   logic signed [fblo_pkg::JKL_W-1:0] j_ff, k4_ff, l_ff;
   // stage 5
   logic signed [SQ_W-1:0] jj_ff, kk_ff, ll_ff;
   logic signed [fblo_pkg::JKL_W-1:0] k5_ff;
   logic signed [fblo_pkg::DEN_W-1:0] den5_ff;
   // stage 6
   logic signed [fblo_pkg::D_W-1:0]   disc_ff;
   logic signed [fblo_pkg::JKL_W-1:0] k6_ff;
   logic signed [fblo_pkg::DEN_W-1:0] den6_ff;

   logic signed [DC_W-1:0] dc_c, dc_s, du;
   logic signed [L2_W-1:0] l2;
   logic signed [JM_W-1:0] jr, kr;

   assign r1 = $signed({1'b0, cfg.ground_len});
   assign r2 = $signed({1'b0, cfg.crank_len});
   assign r3 = $signed({1'b0, cfg.coupler_len});
   assign r4 = $signed({1'b0, cfg.rocker_len});

   // rounding helpers
   always_comb begin
      dc_c = DC_W'(p1c_ff) - DC_W'(p2c_ff) + TRIG_HALF;
      dc_s = DC_W'(p1s_ff) - DC_W'(p2s_ff) + TRIG_HALF;
      du   = DC_W'(pu_ff) + TRIG_HALF;
      jr   = jm_ff + (JM_W'(1) <<< (F - 1));
      kr   = km_ff + (JM_W'(1) <<< (F - 1));
      l2   = L2_W'(rsum3_ff) - (L2_W'(lp_ff) <<< 1) + LEN_HALF;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // products with the CORDIC outputs, constant length terms
         p1c_ff   <= r1 * trig_in.cos1;
         p2c_ff   <= r2 * trig_in.cos2;
         p1s_ff   <= r1 * trig_in.sin1;
         p2s_ff   <= r2 * trig_in.sin2;
         pu_ff    <= r1 * trig_in.cosd;
         rsum1_ff <= RS_W'(r1 * r1) + RS_W'(r2 * r2) + RS_W'(r4 * r4) - RS_W'(r3 * r3);
         // back to length format
         bc_ff    <= fblo_pkg::B_W'(dc_c >>> fblo_pkg::TRIG_FRAC);
         bs_ff    <= fblo_pkg::B_W'(dc_s >>> fblo_pkg::TRIG_FRAC);
         u_ff     <= fblo_pkg::B_W'(du >>> fblo_pkg::TRIG_FRAC);
         rsum2_ff <= rsum1_ff;
         // scale by 2*r4 and r2
         jm_ff    <= $signed({1'b0, cfg.rocker_len, 1'b0}) * bc_ff;
         km_ff    <= $signed({1'b0, cfg.rocker_len, 1'b0}) * bs_ff;
         lp_ff    <= r2 * u_ff;
         rsum3_ff <= rsum2_ff;
         // J, K, L
         j_ff     <= fblo_pkg::JKL_W'(jr >>> F);
         k4_ff    <= fblo_pkg::JKL_W'(kr >>> F);
         l_ff     <= fblo_pkg::JKL_W'(l2 >>> F);
         // squares
         jj_ff    <= j_ff * j_ff;
         kk_ff    <= k4_ff * k4_ff;
         ll_ff    <= l_ff * l_ff;
         k5_ff    <= k4_ff;
         den5_ff  <= fblo_pkg::DEN_W'(l_ff) - fblo_pkg::DEN_W'(j_ff);
         // discriminant
         disc_ff  <= fblo_pkg::D_W'(kk_ff) - fblo_pkg::D_W'(ll_ff) + fblo_pkg::D_W'(jj_ff);
         k6_ff    <= k5_ff;
         den6_ff  <= den5_ff;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= trig_in.valid;
         for (int i = 0; i < 5; i++) vld_ff[i+1] <= vld_ff[i];
      end
   end

   assign jkl_out.valid = vld_ff[5];
   assign jkl_out.disc  = disc_ff;
   assign jkl_out.k     = k6_ff;
   assign jkl_out.den   = den6_ff;

endmodule

// ===== hw/rtl/fblo_sqrt.sv =====
// ----------------------------------------------------------------------------
// fblo_sqrt
// Pipelined integer square root of the discriminant, one result bit per
// stage; flags a negative discriminant and carries K and the denominator.
// ----------------------------------------------------------------------------
module fblo_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  fblo_pkg::jkl_type  jkl_in,
   output fblo_pkg::root_type root_out
);

   localparam int H   = fblo_pkg::ROOT_W;
   localparam int R_W = fblo_pkg::RAD_W + 2;

   logic [R_W-1:0]                    v_ff   [H+1];
   logic [R_W-1:0]                    r_ff   [H+1];
   logic                              neg_ff [H+1];
   logic signed [fblo_pkg::JKL_W-1:0] k_ff   [H+1];
   logic signed [fblo_pkg::DEN_W-1:0] den_ff [H+1];
   logic                              vld_ff [H+1];

   logic                              neg_in;

   assign neg_in = jkl_in.disc[fblo_pkg::D_W-1];

   // digit-by-digit root: one bit pair per stage
   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0]   <= neg_in ? '0 : R_W'(jkl_in.disc[fblo_pkg::RAD_W-1:0]);
         r_ff[0]   <= '0;
         neg_ff[0] <= neg_in;
         k_ff[0]   <= jkl_in.k;
         den_ff[0] <= jkl_in.den;
         for (int i = 0; i < H; i++) begin
            if (v_ff[i] >= r_ff[i] + (R_W'(1) << (2 * (H - 1 - i)))) begin
               v_ff[i+1] <= v_ff[i] - r_ff[i] - (R_W'(1) << (2 * (H - 1 - i)));
               r_ff[i+1] <= (r_ff[i] >> 1) + (R_W'(1) << (2 * (H - 1 - i)));
            end else begin
               v_ff[i+1] <= v_ff[i];
               r_ff[i+1] <= r_ff[i] >> 1;
            end
            neg_ff[i+1] <= neg_ff[i];
            k_ff[i+1]   <= k_ff[i];
            den_ff[i+1] <= den_ff[i];
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < H + 1; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= jkl_in.valid;
         for (int i = 0; i < H; i++) vld_ff[i+1] <= vld_ff[i];
      end
   end

   assign root_out.valid  = vld_ff[H];
   assign root_out.no_asm = neg_ff[H];
   assign root_out.k      = k_ff[H];
   assign root_out.den    = den_ff[H];
   assign root_out.root   = r_ff[H][H-1:0];

endmodule

// ===== hw/rtl/fblo_atan.sv =====
// ----------------------------------------------------------------------------
// fblo_atan
// Numerator/denominator setup, two normalize stages, pipelined CORDIC
// vectoring and the final doubled, rounded angle with status.
// ----------------------------------------------------------------------------
module fblo_atan (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  fblo_pkg::root_type root_in,
   output fblo_pkg::res_type  res_out
);

   localparam int N      = fblo_pkg::CORDIC_STAGES;
   localparam int NW     = fblo_pkg::NORM_W;
   localparam int MW     = fblo_pkg::MAG_W;
   localparam int VW     = fblo_pkg::VEC_W;
   localparam int ZW     = fblo_pkg::Z_W;
   localparam int SH     = fblo_pkg::TURN_W - fblo_pkg::ANGLE_BITS;
   localparam int NSTAGE = N + 4;

   // setup stage
   logic signed [fblo_pkg::NUM_W-1:0] num_c, num_adj;
   logic signed [fblo_pkg::DEN_W-1:0] den_adj;
   logic [fblo_pkg::NUM_W-1:0]        ay_c;
   fblo_pkg::status_type              st_c;
   logic signed [NW-1:0] x0_ff, y0_ff;
   logic [MW-1:0]        m0_ff;
   // normalize stages
   logic signed [NW-1:0] x1_c, y1_c, x2_c, y2_c, x1_ff, y1_ff;
   logic [MW-1:0]        m1_c, m2_c, m1_ff;
   // vectoring
   logic signed [VW-1:0] x_ff [N+1];
   logic signed [VW-1:0] y_ff [N+1];
   logic signed [ZW-1:0] z_ff [N+1];
   fblo_pkg::status_type st_ff [N+3];
   // output
   logic signed [ZW:0]   zr;
   logic [fblo_pkg::ANGLE_BITS-1:0] angle_ff;
   fblo_pkg::status_type st_out_ff;
   logic                 vld_ff [NSTAGE];

   // numerator, sign fix and status
   always_comb begin
      num_c = -fblo_pkg::NUM_W'(root_in.k) - fblo_pkg::NUM_W'(root_in.root);
      if (root_in.den[fblo_pkg::DEN_W-1]) begin
         den_adj = -root_in.den;
         num_adj = -num_c;
      end else begin
         den_adj = root_in.den;
         num_adj = num_c;
      end
      ay_c = num_adj[fblo_pkg::NUM_W-1] ? fblo_pkg::NUM_W'(-num_adj) : num_adj;
      if (root_in.no_asm)
         st_c = fblo_pkg::STATUS_NO_ASSEMBLY;
      else if (root_in.den == '0)
         st_c = fblo_pkg::STATUS_ZERO_DEN;
      else
         st_c = fblo_pkg::STATUS_OK;
   end

   // normalize: shifts of 32, 16, 8 then 4, 2, 1
   always_comb begin
      x1_c = x0_ff;
      y1_c = y0_ff;
      m1_c = m0_ff;
      for (int s = 0; s < 3; s++) begin
         if (m1_c < (MW'(1) << (fblo_pkg::NORM_LIMIT_BIT + 1 - (32 >> s)))) begin
            m1_c = m1_c << (32 >> s);
            x1_c = x1_c <<< (32 >> s);
            y1_c = y1_c <<< (32 >> s);
         end
      end
      x2_c = x1_ff;
      y2_c = y1_ff;
      m2_c = m1_ff;
      for (int s = 0; s < 3; s++) begin
         if (m2_c < (MW'(1) << (fblo_pkg::NORM_LIMIT_BIT + 1 - (4 >> s)))) begin
            m2_c = m2_c << (4 >> s);
            x2_c = x2_c <<< (4 >> s);
            y2_c = y2_c <<< (4 >> s);
         end
      end
   end

   // doubled angle rounded to the output turn
   assign zr = ((ZW + 1)'(z_ff[N]) <<< 1) + ((ZW + 1)'(1) <<< (SH - 1));

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff    <= NW'(den_adj);
         y0_ff    <= NW'(num_adj);
         m0_ff    <= (fblo_pkg::NUM_W'(den_adj) > ay_c) ? MW'(den_adj) : MW'(ay_c);
         st_ff[0] <= st_c;
         x1_ff    <= x1_c;
         y1_ff    <= y1_c;
         m1_ff    <= m1_c;
         st_ff[1] <= st_ff[0];
         x_ff[0]  <= VW'(x2_c);
         y_ff[0]  <= VW'(y2_c);
         z_ff[0]  <= '0;
         st_ff[2] <= st_ff[1];
         for (int i = 0; i < N; i++) begin
            if (!y_ff[i][VW-1]) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ZW'(fblo_pkg::ATAN_TABLE[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ZW'(fblo_pkg::ATAN_TABLE[i]);
            end
            st_ff[i+3] <= st_ff[i+2];
         end
         // special cases override the angle
         case (st_ff[N+2])
            fblo_pkg::STATUS_NO_ASSEMBLY: angle_ff <= '0;
            fblo_pkg::STATUS_ZERO_DEN:
               angle_ff <= fblo_pkg::ANGLE_BITS'(1) << (fblo_pkg::ANGLE_BITS - 1);
            default: angle_ff <= zr[fblo_pkg::TURN_W-1:SH];
         endcase
         st_out_ff <= st_ff[N+2];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTAGE; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= root_in.valid;
         for (int i = 0; i < NSTAGE - 1; i++) vld_ff[i+1] <= vld_ff[i];
      end
   end

   assign res_out.valid  = vld_ff[NSTAGE-1];
   assign res_out.angle  = angle_ff;
   assign res_out.status = st_out_ff;

endmodule

// ===== hw/rtl/four_bar_linkage_output_angle_top.sv =====
// ----------------------------------------------------------------------------
// four_bar_linkage_output_angle_top
// Open-branch output rocker angle of a four-bar linkage for each crank angle.
//
//   channel | direction | handshake         | payload
//   req_    | in        | valid / stall     | crank_angle[15:0]
//   rsp_    | out       | valid / stall     | rocker_angle[15:0], status[1:0]
//   csr_    | in        | valid / ready     | index[2:0], data[15:0]
//
// One request enters per cycle while req_stall is low; each result passes through the
// CORDIC rotate (18 stages), J/K/L math (6), square root (24) and arctangent (20)
// pipelines into a two-entry output queue.
// The pipeline advances as one; it halts only while the output queue is full.
// Synchronous reset clears valid bits and the queue and loads register defaults.
// ----------------------------------------------------------------------------
module four_bar_linkage_output_angle_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fblo_pkg::ANGLE_BITS-1:0]     req_crank_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fblo_pkg::ANGLE_BITS-1:0]     rsp_rocker_angle,
   output logic [fblo_pkg::STATUS_W-1:0]       rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fblo_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fblo_pkg::LEN_W-1:0]          csr_data
);

   localparam int ZPAD = fblo_pkg::TURN_W - fblo_pkg::ANGLE_BITS;

   fblo_pkg::cfg_type              cfg_ff;
   logic [fblo_pkg::ANGLE_BITS-1:0] gangle_ff;
   logic                           en;
   logic [fblo_pkg::TURN_W-1:0]    t1, t2, td;
   fblo_pkg::trig_type             trig_q;
   fblo_pkg::jkl_type              jkl_q;
   fblo_pkg::root_type             root_q;
   fblo_pkg::res_type              res_q;

   logic [fblo_pkg::ANGLE_BITS-1:0] qa_ff [2];
   fblo_pkg::status_type           qs_ff [2];
   logic                           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                     cnt_ff;
   logic                           push, pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ground_len  <= fblo_pkg::GROUND_LEN_RST;
         cfg_ff.crank_len   <= fblo_pkg::CRANK_LEN_RST;
         cfg_ff.coupler_len <= fblo_pkg::COUPLER_LEN_RST;
         cfg_ff.rocker_len  <= fblo_pkg::ROCKER_LEN_RST;
         gangle_ff          <= fblo_pkg::GROUND_ANG_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fblo_pkg::REG_GROUND_LENGTH:  cfg_ff.ground_len  <= csr_data;
            fblo_pkg::REG_CRANK_LENGTH:   cfg_ff.crank_len   <= csr_data;
            fblo_pkg::REG_COUPLER_LENGTH: cfg_ff.coupler_len <= csr_data;
            fblo_pkg::REG_ROCKER_LENGTH:  cfg_ff.rocker_len  <= csr_data;
            fblo_pkg::REG_GROUND_ANGLE:   gangle_ff          <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance: stop only when the output queue is full
   assign en        = (cnt_ff != 2'd2);
   assign req_stall = !en;

   // angles on the 2^32-per-turn accumulator
   assign t1 = {gangle_ff, {ZPAD{1'b0}}};
   assign t2 = {req_crank_angle, {ZPAD{1'b0}}};
   assign td = {req_crank_angle - gangle_ff, {ZPAD{1'b0}}};

   fblo_trig u_trig (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .t1       (t1),
      .t2       (t2),
      .td       (td),
      .trig_out (trig_q)
   );

   fblo_jkl u_jkl (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .cfg     (cfg_ff),
      .trig_in (trig_q),
      .jkl_out (jkl_q)
   );

   fblo_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .jkl_in   (jkl_q),
      .root_out (root_q)
   );

   fblo_atan u_atan (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .root_in (root_q),
      .res_out (res_q)
   );

   // two-entry output queue
   assign push = res_q.valid && en;
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         qa_ff[wr_ptr_ff] <= res_q.angle;
         qs_ff[wr_ptr_ff] <= res_q.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_rocker_angle = qa_ff[rd_ptr_ff];
   assign rsp_status       = qs_ff[rd_ptr_ff];

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Four-bar linkage output angle testbench
// Drives crank angles under several link-length settings and random
// handshake idling, predicts each rocker angle and status with a
// bit-accurate CORDIC model and checks every response in order.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_LATENCY = 80;      // pipeline depth plus margin
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [fblo_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam int NUM_REGS = 5;

   typedef struct {
      logic [fblo_pkg::ANGLE_BITS-1:0] angle;
      fblo_pkg::status_type            status;
   } rocker_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [fblo_pkg::ANGLE_BITS-1:0]  req_crank_angle = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [fblo_pkg::ANGLE_BITS-1:0]  rsp_rocker_angle;
   logic [fblo_pkg::STATUS_W-1:0]    rsp_status;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [fblo_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [fblo_pkg::LEN_W-1:0]       csr_data = '0;

   // predictor copy of the registers, indexed by register index
   logic [15:0]       link_reg [NUM_REGS];
   rocker_result_type rocker_expected [$];
   int                mismatches = 0;
   int                snd_idle = 0;
   int                rcv_idle = 0;
   int                idle_cycles = 0;

   four_bar_linkage_output_angle_top uut (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic void rotate_turn(input bit [31:0] a, output longint c,
                                       output longint s);
      longint x, y, z, nx;
      bit     flip;
      flip = (a > 32'h40000000) && (a < 32'hC0000000);
      if (flip) a = a + 32'h80000000;
      z = longint'($signed(a));
      x = fblo_pkg::CORDIC_XINIT;
      y = 0;
      for (int i = 0; i < fblo_pkg::CORDIC_STAGES; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(fblo_pkg::ATAN_TABLE[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(fblo_pkg::ATAN_TABLE[i]);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint z, nx, ax, ay;
      z  = 0;
      ax = x;
      ay = (y < 0) ? -y : y;
      while (((ax > ay) ? ax : ay) < (longint'(1) <<< fblo_pkg::NORM_LIMIT_BIT)) begin
         x = x * 2; y = y * 2; ax = ax * 2; ay = ay * 2;
      end
      for (int i = 0; i < fblo_pkg::CORDIC_STAGES; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(fblo_pkg::ATAN_TABLE[i]);
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(fblo_pkg::ATAN_TABLE[i]);
         end
         x = nx;
      end
      return z;
   endfunction

   function automatic longint round_down(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic rocker_result_type predict_rocker(
         logic [fblo_pkg::ANGLE_BITS-1:0] crank);
      longint r1, r2, r3, r4, c1, s1, c2, s2, cd, sd, b, jj, kk, ll, u, disc;
      longint num, den, z;
      bit [31:0] t1, t2;
      rocker_result_type res;
      r1 = longint'(link_reg[fblo_pkg::REG_GROUND_LENGTH]);
      r2 = longint'(link_reg[fblo_pkg::REG_CRANK_LENGTH]);
      r3 = longint'(link_reg[fblo_pkg::REG_COUPLER_LENGTH]);
      r4 = longint'(link_reg[fblo_pkg::REG_ROCKER_LENGTH]);
      t1 = {link_reg[fblo_pkg::REG_GROUND_ANGLE], 16'h0};
      t2 = {crank, 16'h0};
      rotate_turn(t1, c1, s1);
      rotate_turn(t2, c2, s2);
      rotate_turn(t2 - t1, cd, sd);
      b  = round_down(r1 * c1 - r2 * c2, fblo_pkg::TRIG_FRAC);
      jj = round_down(2 * r4 * b, fblo_pkg::LENGTH_FRAC_BITS);
      b  = round_down(r1 * s1 - r2 * s2, fblo_pkg::TRIG_FRAC);
      kk = round_down(2 * r4 * b, fblo_pkg::LENGTH_FRAC_BITS);
      u  = round_down(r1 * cd, fblo_pkg::TRIG_FRAC);
      ll = round_down(r1 * r1 + r2 * r2 + r4 * r4 - r3 * r3 - 2 * r2 * u,
                      fblo_pkg::LENGTH_FRAC_BITS);
      disc = kk * kk - ll * ll + jj * jj;
      res.angle  = '0;
      res.status = fblo_pkg::STATUS_OK;
      if (disc < 0) begin
         res.status = fblo_pkg::STATUS_NO_ASSEMBLY;
      end else begin
         num = -kk - longint'(int_sqrt(disc));
         den = ll - jj;
         if (den == 0) begin
            res.angle  = 16'h8000;
            res.status = fblo_pkg::STATUS_ZERO_DEN;
         end else begin
            if (den < 0) begin
               den = -den;
               num = -num;
            end
            z = vector_angle(den, num);
            res.angle = fblo_pkg::ANGLE_BITS'(round_down(2 * z,
                                               32 - fblo_pkg::ANGLE_BITS));
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers
   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle);
   end

   // one crank-angle request; the expectation is queued on acceptance.
   // valid stays up on return so the next request can follow directly.
   task automatic send_crank(logic [fblo_pkg::ANGLE_BITS-1:0] angle);
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_crank_angle <= angle;
      do @(posedge clock); while (req_stall);
      rocker_expected.push_back(predict_rocker(angle));
   endtask

   // drop the request valid; it stays low until the next request
   task automatic stop_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      stop_req();
      while (rocker_expected.size() != 0) @(posedge clock);
   endtask

   // register write, only with the pipeline empty
   task automatic write_reg(logic [fblo_pkg::CSR_INDEX_W-1:0] idx,
                            logic [fblo_pkg::LEN_W-1:0] value);
      wait_drained();
      repeat (PIPE_LATENCY) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < NUM_REGS) link_reg[idx] = value;
   endtask

   task automatic set_links(logic [15:0] g, logic [15:0] c, logic [15:0] cp,
                            logic [15:0] r, logic [15:0] ga);
      write_reg(fblo_pkg::REG_GROUND_LENGTH, g);
      write_reg(fblo_pkg::REG_CRANK_LENGTH, c);
      write_reg(fblo_pkg::REG_COUPLER_LENGTH, cp);
      write_reg(fblo_pkg::REG_ROCKER_LENGTH, r);
      write_reg(fblo_pkg::REG_GROUND_ANGLE, ga);
   endtask

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      rocker_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rocker_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: angle %h status %0d",
                        rsp_rocker_angle, rsp_status);
         end else begin
            exp_res = rocker_expected.pop_front();
            if (rsp_rocker_angle !== exp_res.angle || rsp_status !== exp_res.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: angle exp %h got %h, status exp %0d got %0d",
                           exp_res.angle, rsp_rocker_angle, exp_res.status, rsp_status);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   // reset register values, quadrant corners and angle extremes
   task automatic test_reset_config();
      logic [15:0] corners [10] = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000, 16'h4001,
                                    16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
      foreach (corners[i]) send_crank(corners[i]);
   endtask

   // no assembly, zero denominator, extreme lengths, ignored write
   task automatic test_special_cases();
      set_links(16'd0, 16'd0, 16'd0, 16'd4096, 16'd0);      // cannot assemble
      send_crank(16'h1234);
      send_crank(16'hFFFF);
      set_links(16'd0, 16'd0, 16'd2000, 16'd2000, 16'hFFFF); // zero denominator
      send_crank(16'h0000);
      send_crank(16'h8000);
      set_links(16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);      // all lengths zero
      send_crank(16'h4000);
      set_links(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_crank(16'h0000);
      send_crank(16'h5555);
      send_crank(16'hAAAA);
      set_links(16'd3686, 16'd1229, 16'd0, 16'd3277, 16'h4000); // short coupler
      send_crank(16'h2000);
      send_crank(16'hE000);
      // unused index must leave the registers alone
      write_reg(REG_UNUSED, 16'hFFFF);
      write_reg(REG_UNUSED - 3'd2, 16'h0000);
      send_crank(16'h6000);
   endtask

   // random settings and angles under one idling pattern
   task automatic test_random_phase(int items, int s_idle, int r_idle, bit pause);
      snd_idle = s_idle;
      rcv_idle = r_idle;
      for (int n = 0; n < items; n++) begin
         if (n % 45 == 0) begin
            if ($urandom_range(3) != 0)
               set_links(16'($urandom_range(1000, 8000)), 16'($urandom_range(300, 3000)),
                         16'($urandom_range(1000, 9000)), 16'($urandom_range(1000, 8000)),
                         16'($urandom));
            else
               set_links(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
         end
         // hold off until the pipeline empties, once mid-phase
         if (pause && n == items / 2) wait_drained();
         send_crank(16'($urandom));
      end
   endtask

   initial begin
      link_reg[fblo_pkg::REG_GROUND_LENGTH]  = fblo_pkg::GROUND_LEN_RST;
      link_reg[fblo_pkg::REG_CRANK_LENGTH]   = fblo_pkg::CRANK_LEN_RST;
      link_reg[fblo_pkg::REG_COUPLER_LENGTH] = fblo_pkg::COUPLER_LEN_RST;
      link_reg[fblo_pkg::REG_ROCKER_LENGTH]  = fblo_pkg::ROCKER_LEN_RST;
      link_reg[fblo_pkg::REG_GROUND_ANGLE]   = fblo_pkg::GROUND_ANG_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_special_cases();
      test_random_phase(210, 11, 63, 1'b1);
      test_random_phase(210, 63, 11, 1'b0);
      test_random_phase(210, 0, 0, 1'b1);

      wait_drained();
      repeat (PIPE_LATENCY) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
